### sv/ppps_pkg.sv
// shared types and constants for the pinhole point projection splat
package ppps_pkg;

    localparam int CAM_W      = 17;
    localparam int FOCAL_W    = 12;
    localparam int DIM_W      = 11;
    localparam int PT_W       = 10;
    localparam int DEPTH_W    = 8;
    localparam int COLOR_W    = 8;
    localparam int PIX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int CAM_FRAC   = 4;
    localparam int DX_W       = 18;
    localparam int DEN_W      = 17;
    localparam int PROD_W     = 31;
    localparam int MAG_W      = 30;

    localparam int MAX_DIM_DEF   = 1024;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic signed [CAM_W-1:0] CAM_X_RST  = '0;
    localparam logic signed [CAM_W-1:0] CAM_Y_RST  = '0;
    localparam logic signed [CAM_W-1:0] CAM_Z_RST  = -17'sd4080;
    localparam logic [FOCAL_W-1:0]      FOCAL_RST  = 12'd500;
    localparam logic [DIM_W-1:0]        WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0]        HEIGHT_RST = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_X  = 3'd0,
        CFG_CAM_Y  = 3'd1,
        CFG_CAM_Z  = 3'd2,
        CFG_FOCAL  = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CAM_W-1:0] cam_x;
        logic signed [CAM_W-1:0] cam_y;
        logic signed [CAM_W-1:0] cam_z;
        logic [FOCAL_W-1:0]      focal;
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
    } t_cfg;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_color;

    typedef struct packed {
        logic   keep;
        logic   neg_x;
        logic   neg_y;
        logic   ovf_x;
        logic   ovf_y;
        t_color color;
    } t_side;

endpackage

### sv/ppps_front.sv
// offset, focal multiply and divider setup stages
module ppps_front #(
    parameter int FRAC_BITS = ppps_pkg::FRAC_BITS_DEF,
    parameter int QW        = 19
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppps_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [ppps_pkg::PT_W-1:0]  i_point_x,
    input  logic signed [ppps_pkg::PT_W-1:0]  i_point_y,
    input  logic [ppps_pkg::DEPTH_W-1:0]  i_point_depth,
    input  ppps_pkg::t_color              i_color,
    input  logic                          i_en,
    output logic                          o_valid,
    output ppps_pkg::t_side               o_side,
    output logic [ppps_pkg::DEN_W-1:0]    o_den,
    output logic [ppps_pkg::DEN_W-1:0]    o_rem_x,
    output logic [QW-1:0]                 o_acc_x,
    output logic [ppps_pkg::DEN_W-1:0]    o_rem_y,
    output logic [QW-1:0]                 o_acc_y
);
    import ppps_pkg::*;

    localparam int DW = MAG_W + FRAC_BITS;
    localparam int HW = DW - QW;

    logic en1, en2, en3;

    // stage 1
    logic                    r_v1;
    logic signed [DX_W-1:0]  r_dx1, r_dy1, n_dx1, n_dy1, n_den1;
    logic                    r_keep1;
    logic [DEN_W-1:0]        r_den1;
    t_color                  r_col1;

    // stage 2
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_px2, r_py2, n_px2, n_py2;
    logic                     r_keep2;
    logic [DEN_W-1:0]         r_den2;
    t_color                   r_col2;

    // stage 3
    logic             r_v3;
    t_side            r_side3, n_side3;
    logic [DEN_W-1:0] r_den3, r_remx3, r_remy3, n_remx3, n_remy3;
    logic [QW-1:0]    r_accx3, r_accy3, n_accx3, n_accy3;

    logic signed [PROD_W-1:0] magx_s, magy_s;
    logic [DW-1:0]            divx, divy;
    logic [HW-1:0]            hix, hiy;
    logic signed [FOCAL_W:0]  fs;

    assign en3     = !r_v3 || i_en;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_comb begin
        n_dx1  = DX_W'($signed({i_point_x, {CAM_FRAC{1'b0}}})) - DX_W'(i_cfg.cam_x);
        n_dy1  = DX_W'($signed({i_point_y, {CAM_FRAC{1'b0}}})) - DX_W'(i_cfg.cam_y);
        n_den1 = $signed(DX_W'({i_point_depth, {CAM_FRAC{1'b0}}})) - DX_W'(i_cfg.cam_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
        if (en1) begin
            r_dx1   <= n_dx1;
            r_dy1   <= n_dy1;
            r_den1  <= n_den1[DEN_W-1:0];
            r_keep1 <= !n_den1[DX_W-1] && (n_den1 != '0);
            r_col1  <= i_color;
        end
    end

    always_comb begin
        fs    = $signed({1'b0, i_cfg.focal});
        n_px2 = PROD_W'(fs) * PROD_W'(r_dx1);
        n_py2 = PROD_W'(fs) * PROD_W'(r_dy1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2) begin
            r_px2   <= n_px2;
            r_py2   <= n_py2;
            r_den2  <= r_den1;
            r_keep2 <= r_keep1;
            r_col2  <= r_col1;
        end
    end

    always_comb begin
        magx_s  = r_px2[PROD_W-1] ? -r_px2 : r_px2;
        magy_s  = r_py2[PROD_W-1] ? -r_py2 : r_py2;
        divx    = DW'(magx_s[MAG_W-1:0]) << FRAC_BITS;
        divy    = DW'(magy_s[MAG_W-1:0]) << FRAC_BITS;
        hix     = divx[DW-1:QW];
        hiy     = divy[DW-1:QW];
        n_side3.keep  = r_keep2;
        n_side3.neg_x = r_px2[PROD_W-1];
        n_side3.neg_y = r_py2[PROD_W-1];
        n_side3.ovf_x = hix >= HW'(r_den2);
        n_side3.ovf_y = hiy >= HW'(r_den2);
        n_side3.color = r_col2;
        n_remx3 = hix[DEN_W-1:0];
        n_remy3 = hiy[DEN_W-1:0];
        n_accx3 = divx[QW-1:0];
        n_accy3 = divy[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
        if (en3) begin
            r_side3 <= n_side3;
            r_den3  <= r_den2;
            r_remx3 <= n_remx3;
            r_remy3 <= n_remy3;
            r_accx3 <= n_accx3;
            r_accy3 <= n_accy3;
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_side3;
    assign o_den   = r_den3;
    assign o_rem_x = r_remx3;
    assign o_acc_x = r_accx3;
    assign o_rem_y = r_remy3;
    assign o_acc_y = r_accy3;

endmodule

### sv/ppps_div.sv
// pipelined restoring divider, one quotient bit per stage, x and y lanes
module ppps_div #(
    parameter int QW = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_en,
    input  ppps_pkg::t_side            i_side,
    input  logic [ppps_pkg::DEN_W-1:0] i_den,
    input  logic [ppps_pkg::DEN_W-1:0] i_rem_x,
    input  logic [QW-1:0]              i_acc_x,
    input  logic [ppps_pkg::DEN_W-1:0] i_rem_y,
    input  logic [QW-1:0]              i_acc_y,
    input  logic                       i_en,
    output logic                       o_valid,
    output ppps_pkg::t_side            o_side,
    output logic [QW-1:0]              o_quot_x,
    output logic [QW-1:0]              o_quot_y
);
    import ppps_pkg::*;

    function automatic logic [DEN_W+QW-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [QW-1:0]    acc,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   d;
        logic [DEN_W-1:0] rn;
        logic             q;
        t = {rem, acc[QW-1]};
        d = {1'b0, den};
        q = t >= d;
        rn = q ? DEN_W'(t - d) : t[DEN_W-1:0];
        return {rn, acc[QW-2:0], q};
    endfunction

    logic [QW:0]      en_c;
    logic [QW-1:0]    r_v;
    t_side            r_side [QW];
    logic [DEN_W-1:0] r_den  [QW];
    logic [DEN_W-1:0] r_remx [QW];
    logic [DEN_W-1:0] r_remy [QW];
    logic [QW-1:0]    r_accx [QW];
    logic [QW-1:0]    r_accy [QW];

    assign en_c[QW] = i_en;
    assign o_en     = en_c[0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             v_in;
        t_side            side_in;
        logic [DEN_W-1:0] den_in, remx_in, remy_in;
        logic [QW-1:0]    accx_in, accy_in;
        logic [DEN_W+QW-1:0] n_x, n_y;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign den_in  = i_den;
            assign remx_in = i_rem_x;
            assign remy_in = i_rem_y;
            assign accx_in = i_acc_x;
            assign accy_in = i_acc_y;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign side_in = r_side[k-1];
            assign den_in  = r_den[k-1];
            assign remx_in = r_remx[k-1];
            assign remy_in = r_remy[k-1];
            assign accx_in = r_accx[k-1];
            assign accy_in = r_accy[k-1];
        end

        assign en_c[k] = !r_v[k] || en_c[k+1];
        assign n_x     = div_step(remx_in, accx_in, den_in);
        assign n_y     = div_step(remy_in, accy_in, den_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en_c[k]) begin
                r_v[k] <= v_in;
            end
            if (en_c[k]) begin
                r_side[k] <= side_in;
                r_den[k]  <= den_in;
                r_remx[k] <= n_x[DEN_W+QW-1:QW];
                r_accx[k] <= n_x[QW-1:0];
                r_remy[k] <= n_y[DEN_W+QW-1:QW];
                r_accy[k] <= n_y[QW-1:0];
            end
        end
    end

    assign o_valid  = r_v[QW-1];
    assign o_side   = r_side[QW-1];
    assign o_quot_x = r_accx[QW-1];
    assign o_quot_y = r_accy[QW-1];

endmodule

### sv/ppps_back.sv
// sign restore, centering, frame test and output register
module ppps_back #(
    parameter int MAX_DIM   = ppps_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = ppps_pkg::FRAC_BITS_DEF,
    parameter int QW        = 19
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppps_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_en,
    input  ppps_pkg::t_side              i_side,
    input  logic [QW-1:0]                i_quot_x,
    input  logic [QW-1:0]                i_quot_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ppps_pkg::PIX_W-1:0]   o_pixel_col,
    output logic [ppps_pkg::PIX_W-1:0]   o_pixel_row,
    output ppps_pkg::t_color             o_color
);
    import ppps_pkg::*;

    localparam int CW = $clog2(MAX_DIM) + 1;
    localparam int SW = QW + 2;

    logic en_b1, en_out;

    logic                 r_v1;
    t_side                r_side1;
    logic signed [QW:0]   r_qx1, r_qy1;

    logic [CW-1:0]        w_c, h_c;
    logic signed [SW-1:0] colf, rowf, wlim, hlim;
    logic                 in_x, in_y;

    logic                 r_ov;
    logic [PIX_W-1:0]     r_col, r_row;
    t_color               r_color;

    assign en_out = !r_ov || !i_stall;
    assign en_b1  = !r_v1 || en_out;
    assign o_en   = en_b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en_b1) begin
            r_v1 <= i_valid;
        end
        if (en_b1) begin
            r_side1 <= i_side;
            r_qx1   <= i_side.neg_x ? -$signed({1'b0, i_quot_x}) : $signed({1'b0, i_quot_x});
            r_qy1   <= i_side.neg_y ? -$signed({1'b0, i_quot_y}) : $signed({1'b0, i_quot_y});
        end
    end

    always_comb begin
        w_c  = (32'(i_cfg.width) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(i_cfg.width);
        h_c  = (32'(i_cfg.height) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(i_cfg.height);
        wlim = $signed(SW'(w_c) << FRAC_BITS);
        hlim = $signed(SW'(h_c) << FRAC_BITS);
        colf = $signed(SW'(w_c >> 1) << FRAC_BITS) + SW'(r_qx1);
        rowf = $signed(SW'(h_c >> 1) << FRAC_BITS) - SW'(r_qy1);
        in_x = !r_side1.ovf_x && (colf > 0) && (colf < wlim);
        in_y = !r_side1.ovf_y && (rowf > 0) && (rowf < hlim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_v1 && r_side1.keep && in_x && in_y;
        end
        if (en_out) begin
            r_col   <= PIX_W'(colf >>> FRAC_BITS);
            r_row   <= PIX_W'(rowf >>> FRAC_BITS);
            r_color <= r_side1.color;
        end
    end

    assign o_valid     = r_ov;
    assign o_pixel_col = r_col;
    assign o_pixel_row = r_row;
    assign o_color     = r_color;

endmodule

### sv/pinhole_point_projection_splat.sv
// top level: config registers and the projection pipeline
// quotient width QW = clog2(MAX_DIM) + FRAC_BITS + 1 (19 at the defaults)
// throughput: one point per cycle while i_stall is low; the divider retires one quotient bit per stage
// dropped points leave a bubble and produce no transfer
// synchronous active-low reset empties the pipeline and loads the default camera
module pinhole_point_projection_splat #(
    parameter int MAX_DIM   = ppps_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = ppps_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [ppps_pkg::PT_W-1:0] i_point_x,
    input  logic signed [ppps_pkg::PT_W-1:0] i_point_y,
    input  logic [ppps_pkg::DEPTH_W-1:0]    i_point_depth,
    input  logic [ppps_pkg::COLOR_W-1:0]    i_blue,
    input  logic [ppps_pkg::COLOR_W-1:0]    i_green,
    input  logic [ppps_pkg::COLOR_W-1:0]    i_red,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ppps_pkg::PIX_W-1:0]      o_pixel_col,
    output logic [ppps_pkg::PIX_W-1:0]      o_pixel_row,
    output logic [ppps_pkg::COLOR_W-1:0]    o_out_blue,
    output logic [ppps_pkg::COLOR_W-1:0]    o_out_green,
    output logic [ppps_pkg::COLOR_W-1:0]    o_out_red
);
    import ppps_pkg::*;

    localparam int QW = $clog2(MAX_DIM) + FRAC_BITS + 1;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_x  <= CAM_X_RST;
            r_cfg.cam_y  <= CAM_Y_RST;
            r_cfg.cam_z  <= CAM_Z_RST;
            r_cfg.focal  <= FOCAL_RST;
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAM_X:  r_cfg.cam_x  <= $signed(i_cfg_data[CAM_W-1:0]);
                CFG_CAM_Y:  r_cfg.cam_y  <= $signed(i_cfg_data[CAM_W-1:0]);
                CFG_CAM_Z:  r_cfg.cam_z  <= $signed(i_cfg_data[CAM_W-1:0]);
                CFG_FOCAL:  r_cfg.focal  <= i_cfg_data[FOCAL_W-1:0];
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    t_color           in_color, out_color;
    logic             f_valid, d_en, d_valid, b_en;
    t_side            f_side, d_side;
    logic [DEN_W-1:0] f_den, f_rem_x, f_rem_y;
    logic [QW-1:0]    f_acc_x, f_acc_y, d_quot_x, d_quot_y;

    assign in_color.blue  = i_blue;
    assign in_color.green = i_green;
    assign in_color.red   = i_red;

    ppps_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .i_point_depth(i_point_depth), .i_color(in_color),
        .i_en(d_en), .o_valid(f_valid), .o_side(f_side), .o_den(f_den),
        .o_rem_x(f_rem_x), .o_acc_x(f_acc_x), .o_rem_y(f_rem_y), .o_acc_y(f_acc_y)
    );

    ppps_div #(.QW(QW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_en(d_en), .i_side(f_side), .i_den(f_den),
        .i_rem_x(f_rem_x), .i_acc_x(f_acc_x), .i_rem_y(f_rem_y), .i_acc_y(f_acc_y),
        .i_en(b_en), .o_valid(d_valid), .o_side(d_side),
        .o_quot_x(d_quot_x), .o_quot_y(d_quot_y)
    );

    ppps_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(d_valid), .o_en(b_en), .i_side(d_side),
        .i_quot_x(d_quot_x), .i_quot_y(d_quot_y),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pixel_col(o_pixel_col), .o_pixel_row(o_pixel_row), .o_color(out_color)
    );

    assign o_out_blue  = out_color.blue;
    assign o_out_green = out_color.green;
    assign o_out_red   = out_color.red;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side can move");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(d_valid, 2))
        else $error("result without an item leaving the divider");

endmodule
